### rtl/core/kcl_pkg.sv
// Package with shared types and constants of the keypad code lock.
`timescale 1ns / 1ps
package kcl_pkg;

  localparam int MAX_KEYS_DEF = 8;

  localparam logic [1:0] REG_CODE_KEYS    = 2'd0;
  localparam logic [1:0] REG_CODE_LENGTH  = 2'd1;
  localparam logic [1:0] REG_WRONG_HOLD   = 2'd2;
  localparam logic [1:0] REG_DEFUSED_HOLD = 2'd3;

  localparam logic [31:0] CODE_KEYS_RST    = 32'h0000_1234;
  localparam logic [3:0]  CODE_LENGTH_RST  = 4'd4;
  localparam logic [15:0] WRONG_HOLD_RST   = 16'd14;
  localparam logic [15:0] DEFUSED_HOLD_RST = 16'd600;

  localparam logic [4:0] KEY_RELEASED = 5'd17;

  localparam logic [1:0] LOCK_ACTIVE  = 2'd0;
  localparam logic [1:0] LOCK_WRONG   = 2'd1;
  localparam logic [1:0] LOCK_DEFUSED = 2'd2;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    MODE_ACTIVE  = 3'b001,
    MODE_WRONG   = 3'b010,
    MODE_DEFUSED = 3'b100
  } mode_t;

  typedef struct packed {
    logic [31:0] code_keys;
    logic [3:0]  code_length;
    logic [15:0] wrong_hold_ticks;
    logic [15:0] defused_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [4:0] key_code;
  } item_t;

  typedef struct packed {
    logic [1:0]  lock_state;
    logic [3:0]  entry_count;
    logic [31:0] entry_keys;
    logic        key_accepted;
    logic        green_light;
  } result_t;

endpackage

### rtl/core/kcl_config.sv
// Configuration registers of the keypad code lock.
`timescale 1ns / 1ps
module kcl_config import kcl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_keys          <= CODE_KEYS_RST;
      cfg.code_length        <= CODE_LENGTH_RST;
      cfg.wrong_hold_ticks   <= WRONG_HOLD_RST;
      cfg.defused_hold_ticks <= DEFUSED_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODE_KEYS:    cfg.code_keys          <= cfg_data;
        REG_CODE_LENGTH:  cfg.code_length        <= cfg_data[3:0];
        REG_WRONG_HOLD:   cfg.wrong_hold_ticks   <= cfg_data[15:0];
        REG_DEFUSED_HOLD: cfg.defused_hold_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/kcl_input_stage.sv
// Input register stage of the keypad code lock.
`timescale 1ns / 1ps
module kcl_input_stage import kcl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [4:0] key_code,
  output logic       item_valid,
  output item_t      item,
  input  logic       item_take
);

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.command  <= command;
      item.key_code <= key_code;
    end
  end

endmodule

### rtl/core/kcl_engine.sv
// Lock state and per-word update logic of the keypad code lock.
`timescale 1ns / 1ps
module kcl_engine import kcl_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  localparam int KEY_LIMIT_I = (MAX_KEYS > 8) ? 8 : ((MAX_KEYS < 1) ? 1 : MAX_KEYS);
  localparam logic [3:0] KEY_LIMIT = 4'(KEY_LIMIT_I);

  mode_t       mode, mode_next;
  logic [4:0]  previous_key, previous_key_next;
  logic [31:0] entered, entered_next;
  logic [3:0]  entered_count, entered_count_next;
  logic [15:0] hold_left, hold_left_next;
  logic        accepted;

  logic [3:0]  used_len;
  logic [31:0] mask;
  logic [31:0] appended;
  logic [3:0]  count_plus;

  always_comb begin
    used_len = cfg.code_length;
    if (used_len == 4'd0) used_len = 4'd1;
    if (used_len > KEY_LIMIT) used_len = KEY_LIMIT;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[4*i +: 4] = (4'(i) < used_len) ? 4'hF : 4'h0;
    end
  end

  always_comb begin
    appended   = entered;
    count_plus = entered_count;
    if (entered_count < KEY_LIMIT) begin
      appended   = entered | ({28'd0, item.key_code[3:0]} << {entered_count, 2'b00});
      count_plus = entered_count + 4'd1;
    end
  end

  always_comb begin
    mode_next          = mode;
    previous_key_next  = previous_key;
    entered_next       = entered;
    entered_count_next = entered_count;
    hold_left_next     = hold_left;
    accepted           = 1'b0;
    if (item.command == CMD_TICK) begin
      if (mode != MODE_ACTIVE) begin
        if (hold_left > 16'd1) begin
          hold_left_next = hold_left - 16'd1;
        end else begin
          mode_next          = MODE_ACTIVE;
          entered_next       = '0;
          entered_count_next = '0;
          hold_left_next     = '0;
        end
      end
    end else if (item.key_code > 5'd15) begin
      previous_key_next = KEY_RELEASED;
    end else if (item.key_code != previous_key && mode == MODE_ACTIVE) begin
      accepted           = 1'b1;
      previous_key_next  = item.key_code;
      entered_next       = appended;
      entered_count_next = count_plus;
      if (count_plus >= used_len) begin
        if ((appended & mask) == (cfg.code_keys & mask)) begin
          mode_next      = MODE_DEFUSED;
          hold_left_next = cfg.defused_hold_ticks;
        end else begin
          mode_next      = MODE_WRONG;
          hold_left_next = cfg.wrong_hold_ticks;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_ACTIVE;
      previous_key  <= KEY_RELEASED;
      entered       <= '0;
      entered_count <= '0;
      hold_left     <= '0;
    end else if (fire) begin
      mode          <= mode_next;
      previous_key  <= previous_key_next;
      entered       <= entered_next;
      entered_count <= entered_count_next;
      hold_left     <= hold_left_next;
    end
  end

  always_comb begin
    case (mode_next)
      MODE_ACTIVE:  result.lock_state = LOCK_ACTIVE;
      MODE_WRONG:   result.lock_state = LOCK_WRONG;
      MODE_DEFUSED: result.lock_state = LOCK_DEFUSED;
      default:      result.lock_state = LOCK_ACTIVE;
    endcase
    result.entry_count  = entered_count_next;
    result.entry_keys   = entered_next;
    result.key_accepted = accepted;
    result.green_light  = (mode_next == MODE_DEFUSED);
  end

endmodule

### rtl/core/kcl_output_stage.sv
// Result register stage of the keypad code lock.
`timescale 1ns / 1ps
module kcl_output_stage import kcl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  output logic    can_load,
  input  result_t result,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result_q
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      result_q <= result;
    end
  end

endmodule

### rtl/core/keypad_code_lock.sv
// Top level of the keypad code lock.
// A word passes through the input register and then the result register on its way to the output.
// Throughput: one word per cycle while the output is not stalled; the state update sets the rate.
// Stalls on the output side back up through the input register.
// Reset (rst, synchronous, active high): lock active, entry empty, key released,
// configuration registers back to their defaults, both stages empty.
`timescale 1ns / 1ps
module keypad_code_lock import kcl_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [4:0]  key_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  lock_state,
  output logic [3:0]  entry_count,
  output logic [31:0] entry_keys,
  output logic        key_accepted,
  output logic        green_light
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    can_load;
  logic    fire;
  result_t result;
  result_t result_q;

  assign fire = item_valid && can_load;

  kcl_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kcl_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .key_code   (key_code),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (can_load)
  );

  kcl_engine #(
    .MAX_KEYS (MAX_KEYS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  kcl_output_stage u_output (
    .clk       (clk),
    .rst       (rst),
    .load      (item_valid),
    .can_load  (can_load),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_q  (result_q)
  );

  assign lock_state   = result_q.lock_state;
  assign entry_count  = result_q.entry_count;
  assign entry_keys   = result_q.entry_keys;
  assign key_accepted = result_q.key_accepted;
  assign green_light  = result_q.green_light;

  a_green_defused: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (green_light == (lock_state == LOCK_DEFUSED)))
    else $error("green light disagrees with lock state");

  a_accept_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && key_accepted) |-> (entry_count != 4'd0))
    else $error("key accepted with empty entry");

  a_active_empty_on_tick: assert property (@(posedge clk) disable iff (rst)
    (fire && item.command == CMD_TICK && result.lock_state == LOCK_ACTIVE
     && result.entry_count == 4'd0) |-> (result.entry_keys == 32'd0))
    else $error("entry keys left after clearing");

  a_output_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule
